### sv/sstf_pkg.sv
// ----------------------------------------------------------------------------
// sstf_pkg
// shared types and constants of the shortest-seek-first request orderer
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int MAX_REQUESTS = 64;
  localparam int TRACK_BITS   = 16;
  localparam int TOTAL_BITS   = 22;
  localparam int IDX_BITS     = $clog2(MAX_REQUESTS);
  localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);
  localparam int CFG_BITS     = 16;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0]   CNT_FULL  = CNT_BITS'(MAX_REQUESTS);

  // register index, taken from paddr[2]
  localparam logic REG_HEAD_START = 1'b0;

  typedef struct packed {
    logic [TRACK_BITS-1:0] track;
    logic                  last;
  } req_t;

  typedef struct packed {
    logic [TRACK_BITS-1:0] from_track;
    logic [TRACK_BITS-1:0] to_track;
    logic [TRACK_BITS-1:0] seek_distance;
    logic [TOTAL_BITS-1:0] total_moves;
    logic                  overflow;
    logic                  last_move;
  } res_t;

  // one beat of store data presented to the compare unit
  typedef struct packed {
    logic                  clr;
    logic                  vld;
    logic [IDX_BITS-1:0]   idx;
    logic [TRACK_BITS-1:0] trk;
  } scan_ctl_t;

  // best candidate found so far
  typedef struct packed {
    logic                  found;
    logic [IDX_BITS-1:0]   idx;
    logic [TRACK_BITS-1:0] gap;
    logic [TRACK_BITS-1:0] trk;
  } scan_best_t;

endpackage

### sv/sstf_ram.sv
// ----------------------------------------------------------------------------
// sstf_ram
// generic one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module sstf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/sstf_scan.sv
// ----------------------------------------------------------------------------
// sstf_scan
// shared distance and compare unit, one store entry per cycle
// ----------------------------------------------------------------------------
module sstf_scan (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [sstf_pkg::TRACK_BITS-1:0] head,
  input  sstf_pkg::scan_ctl_t            ctl,
  output sstf_pkg::scan_best_t           best
);
  import sstf_pkg::*;

  logic [TRACK_BITS-1:0] gap;
  logic                  take;

  // absolute distance from the head
  assign gap  = (head >= ctl.trk) ? (head - ctl.trk) : (ctl.trk - head);
  // ties go to the later entry
  assign take = ctl.vld && (!best.found || gap <= best.gap);

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      best.found <= 1'b0;
    end else if (take) begin
      best.found <= 1'b1;
    end
    if (take) begin
      best.idx <= ctl.idx;
      best.gap <= gap;
      best.trk <= ctl.trk;
    end
  end

endmodule

### sv/sstf_seek_order.sv
// ----------------------------------------------------------------------------
// sstf_seek_order
// shortest-seek-time-first ordering of a batch of track requests
// ----------------------------------------------------------------------------
// usage:
//   requests come in as command beats: a beat is taken when start is high
//   and busy is low. beats are stored until the one with last set; that beat
//   is stored too and the batch is then served from head_start. requests
//   past the store depth are dropped and overflow is set on every result.
//   each move comes out on res for exactly one cycle with res_valid high;
//   the receiver cannot stall, so results are never held back.
// timing:
//   loading accepts one beat per cycle and busy stays low. after the last
//   beat busy is high while the batch is served. each pick walks the
//   request store through its single read port: a read is issued for each
//   stored entry, the registered read data goes to the compare unit, the
//   scan is closed and the move is then put out on res. the
//   distance compare unit is shared by all picks.
// reset:
//   rst is synchronous; it clears head_start, the batch count, served marks,
//   running total and overflow. the store itself needs no clearing.
// ----------------------------------------------------------------------------
module sstf_seek_order (
  input  logic                 clk,
  input  logic                 rst,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  sstf_pkg::req_t       req,
  // result channel
  output logic                 res_valid,
  output sstf_pkg::res_t       res,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import sstf_pkg::*;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state;
  logic [CFG_BITS-1:0]   head_start;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   iss;
  logic [CNT_BITS-1:0]   pick;
  logic                  rd_vld;
  logic [IDX_BITS-1:0]   rd_idx;
  logic [MAX_REQUESTS-1:0] served;
  logic [TRACK_BITS-1:0] head;
  logic [TOTAL_BITS-1:0] total;
  logic [TOTAL_BITS-1:0] total_next;
  logic [TOTAL_BITS:0]   total_sum;
  logic                  dropped;

  logic                  accept;
  logic                  accept_last;
  logic                  store_we;
  logic                  last_pick;
  logic                  scan_done;
  logic                  cfg_wr;
  logic [TRACK_BITS-1:0] rd_data;
  scan_ctl_t             ctl;
  scan_best_t            best;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_start <= '0;
    end else if (cfg_wr && paddr[2] == REG_HEAD_START) begin
      head_start <= pwdata[CFG_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HEAD_START) begin
      prdata = 32'(head_start);
    end
  end

  // ---------------------------------------------------------------- loading
  assign busy        = (state != ST_LOAD);
  assign accept      = start && !busy;
  assign accept_last = accept && req.last;
  assign store_we    = accept && (count < CNT_FULL);

  sstf_ram #(
    .WIDTH (TRACK_BITS),
    .DEPTH (MAX_REQUESTS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[IDX_BITS-1:0]),
    .wdata (req.track),
    .raddr (iss[IDX_BITS-1:0]),
    .rdata (rd_data)
  );

  // ---------------------------------------------------------------- scan
  // a read is issued while iss < count; its data shows up in the next cycle
  assign scan_done = (iss == count) && !rd_vld;
  assign last_pick = (pick == count - CNT_BITS'(1));

  assign ctl.clr = accept_last || (state == ST_EMIT);
  assign ctl.vld = rd_vld && !served[rd_idx];
  assign ctl.idx = rd_idx;
  assign ctl.trk = rd_data;

  sstf_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .ctl  (ctl),
    .best (best)
  );

  // saturating running total
  assign total_sum  = {1'b0, total} + (TOTAL_BITS+1)'(best.gap);
  assign total_next = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      iss     <= '0;
      pick    <= '0;
      rd_vld  <= 1'b0;
      served  <= '0;
      head    <= '0;
      total   <= '0;
      dropped <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (store_we) begin
              count <= count + CNT_BITS'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (req.last) begin
              head   <= head_start[TRACK_BITS-1:0];
              iss    <= '0;
              pick   <= '0;
              rd_vld <= 1'b0;
              state  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (iss < count) begin
            iss    <= iss + CNT_BITS'(1);
            rd_vld <= 1'b1;
            rd_idx <= iss[IDX_BITS-1:0];
          end else begin
            rd_vld <= 1'b0;
          end
          if (scan_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // result beat goes out this cycle
          head   <= best.trk;
          pick   <= pick + CNT_BITS'(1);
          iss    <= '0;
          rd_vld <= 1'b0;
          if (last_pick) begin
            // batch finished, clear it for the next one
            served  <= '0;
            count   <= '0;
            total   <= '0;
            dropped <= 1'b0;
            state   <= ST_LOAD;
          end else begin
            served[best.idx] <= 1'b1;
            total            <= total_next;
            state            <= ST_SCAN;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- result
  assign res_valid         = (state == ST_EMIT);
  assign res.from_track    = head;
  assign res.to_track      = best.trk;
  assign res.seek_distance = best.gap;
  assign res.total_moves   = total_next;
  assign res.overflow      = dropped;
  assign res.last_move     = last_pick;

  // ---------------------------------------------------------------- checks
  // two result beats always have a scan between them
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !res_valid)
    else $error("result beats back to back");

  // a result only comes from a pick that found an unserved entry
  a_pick_found: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> best.found)
    else $error("result without a candidate");

  // the final move returns the block to loading
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last_move |=> !busy)
    else $error("block still busy after final move");

  // the last beat of a batch starts serving
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    accept_last |=> busy && count != '0)
    else $error("batch not served after last beat");

endmodule
